// ===== design/kcf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcf_pkg: shared types and constants of the key chatter filter
// Verdict codes, item kinds, register indexes, history entry and probe types.
// ----------------------------------------------------------------------------
package kcf_pkg;

   // field widths
   localparam int KEY_W   = 8;
   localparam int TIME_W  = 16;
   localparam int CODE_W  = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;

   // register reset values
   localparam logic [TIME_W-1:0] REPRESS_WINDOW_RST = 16'd24;
   localparam logic [TIME_W-1:0] SHORT_WINDOW_RST   = 16'd18;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_REPRESS_WINDOW = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_WINDOW   = 1'b1;

   // item kinds
   localparam logic FUNC_KEY  = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   typedef enum logic [2:0] {
      VERDICT_PASS     = 3'd0,
      VERDICT_BLOCKED  = 3'd1,
      VERDICT_WITHHELD = 3'd2,
      VERDICT_ABSORBED = 3'd3,
      VERDICT_ISSUED   = 3'd4,
      VERDICT_IDLE     = 3'd5
   } verdict_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_BUSY = 1'b1
   } state_type;

   // one history entry: key position and timestamp
   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] stamp;
   } entry_type;

   // search probe handed from cell to cell
   typedef struct packed {
      logic              valid;
      logic [KEY_W-1:0]  key;
      logic              hit;
      logic [TIME_W-1:0] stamp;
   } probe_type;

endpackage

// ===== design/kcf_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcf_cell: one history slot of the key chatter filter
// Holds one entry, shifts it on to the older neighbor on a push, and checks
// the passing search probe against its entry.
// ----------------------------------------------------------------------------
module kcf_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift_en,
   input  kcf_pkg::entry_type prev_entry,
   input  kcf_pkg::probe_type prev_probe,
   output kcf_pkg::entry_type entry,
   output kcf_pkg::probe_type probe
);

   kcf_pkg::entry_type entry_ff;
   kcf_pkg::entry_type entry_in;
   kcf_pkg::probe_type probe_ff;
   kcf_pkg::probe_type probe_in;

   // entry takes the newer neighbor's entry on a push
   always_comb begin
      entry_in = shift_en ? prev_entry : entry_ff;
   end

   // first matching entry on the walk marks the probe
   always_comb begin
      probe_in = prev_probe;
      if (prev_probe.valid && !prev_probe.hit && (entry_ff.key == prev_probe.key)) begin
         probe_in.hit   = 1'b1;
         probe_in.stamp = entry_ff.stamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         probe_ff <= '0;
      end else begin
         entry_ff <= entry_in;
         probe_ff <= probe_in;
      end
   end

   assign entry = entry_ff;
   assign probe = probe_ff;

endmodule

// ===== design/key_chatter_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_chatter_filter: contact chatter filter for key events
// Blocks fast re-presses, withholds short releases and issues them on ticks.
// ----------------------------------------------------------------------------
// Usage
//   req_*  : one item per transfer, a key event (req_func 0) or a time tick
//            (req_func 1, only req_event_time is used).
//   rsp_*  : exactly one result per item, in item order.
//   csr_*  : write-only window registers, to be written by the user while the block is idle.
// Timing
//   A key event walks a row of HISTORY_DEPTH cells, one cell a cycle, and
//   its verdict is formed once the walk result is latched. One item is in
//   work at a time; req_stall is high while it is. The next item is taken
//   while the previous result still waits in the output register.
// Stall
//   While rsp_stall holds the output register full, a finished item waits
//   and updates no state until its result can be loaded.
// Reset
//   History reads as key 0 at time 0 in every slot, no release pending,
//   windows back to 24 ms and 18 ms, no result valid.
// ----------------------------------------------------------------------------
module key_chatter_filter #(
   parameter int HISTORY_DEPTH = 6
) (
   input  logic        clock,
   input  logic        reset,
   // item channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [3:0]  req_key_row,
   input  logic [3:0]  req_key_col,
   input  logic        req_pressed,
   input  logic [15:0] req_event_time,
   input  logic [15:0] req_keycode,
   input  logic        req_game_mode,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_verdict,
   output logic [15:0] rsp_release_keycode,
   // register writes
   input  logic        csr_wr_en,
   input  logic [kcf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kcf_pkg::CSR_DATA_W-1:0] csr_wdata
);

   // window registers
   logic [kcf_pkg::TIME_W-1:0] repress_ff, repress_in;
   logic [kcf_pkg::TIME_W-1:0] short_ff, short_in;

   // control
   kcf_pkg::state_type state_ff, state_in;
   logic req_transfer;
   logic finish;

   // item under work
   logic                       func_ff;
   logic [kcf_pkg::KEY_W-1:0]  key_ff;
   logic                       pressed_ff;
   logic [kcf_pkg::TIME_W-1:0] time_ff;
   logic [kcf_pkg::CODE_W-1:0] code_ff;
   logic                       game_ff;

   // walk result
   logic                       walk_done_ff, walk_done_in;
   logic                       walk_hit_ff;
   logic [kcf_pkg::TIME_W-1:0] walk_time_ff;

   // pending release
   logic                       pend_valid_ff, pend_valid_in;
   logic [kcf_pkg::KEY_W-1:0]  pend_key_ff;
   logic [kcf_pkg::CODE_W-1:0] pend_code_ff;
   logic [kcf_pkg::TIME_W-1:0] pend_time_ff;
   logic                       pend_load;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   kcf_pkg::verdict_type       rsp_verdict_ff;
   logic [kcf_pkg::CODE_W-1:0] rsp_code_ff;

   // decision
   kcf_pkg::verdict_type       verdict;
   logic [kcf_pkg::CODE_W-1:0] rel_code;
   logic                       push;
   logic [kcf_pkg::TIME_W-1:0] pend_age;
   logic [kcf_pkg::TIME_W-1:0] delta;

   // cell row
   kcf_pkg::entry_type new_entry;
   kcf_pkg::probe_type inject;
   kcf_pkg::entry_type entry_chain [HISTORY_DEPTH];
   kcf_pkg::probe_type probe_chain [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0] probe_live;

   assign req_transfer = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kcf_pkg::ST_IDLE: if (req_transfer) state_in = kcf_pkg::ST_BUSY;
         kcf_pkg::ST_BUSY: if (finish) state_in = kcf_pkg::ST_IDLE;
         default:          state_in = kcf_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      finish    = 1'b0;
      unique case (state_ff)
         kcf_pkg::ST_IDLE: req_stall = 1'b0;
         kcf_pkg::ST_BUSY: begin
            finish = ((func_ff == kcf_pkg::FUNC_TICK) || walk_done_ff)
                     && !(rsp_valid_ff && rsp_stall);
         end
         default: req_stall = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= kcf_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   // register writes
   always_comb begin
      repress_in = repress_ff;
      short_in   = short_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            kcf_pkg::CSR_REPRESS_WINDOW: repress_in = csr_wdata;
            kcf_pkg::CSR_SHORT_WINDOW:   short_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         repress_ff <= kcf_pkg::REPRESS_WINDOW_RST;
         short_ff   <= kcf_pkg::SHORT_WINDOW_RST;
      end else begin
         repress_ff <= repress_in;
         short_ff   <= short_in;
      end
   end

   // capture the item on transfer
   always_ff @(posedge clock) begin
      if (req_transfer) begin
         func_ff    <= req_func;
         key_ff     <= {req_key_row, req_key_col};
         pressed_ff <= req_pressed;
         time_ff    <= req_event_time;
         code_ff    <= req_keycode;
         game_ff    <= req_game_mode;
      end
   end

   // probe enters the first cell with the transfer of a key event
   always_comb begin
      inject       = '0;
      inject.valid = req_transfer && (req_func == kcf_pkg::FUNC_KEY);
      inject.key   = {req_key_row, req_key_col};
   end

   assign new_entry.key   = key_ff;
   assign new_entry.stamp = time_ff;

   // row of history cells, newest first
   genvar gi;
   generate
      for (gi = 0; gi < HISTORY_DEPTH; gi++) begin : g_cell
         if (gi == 0) begin : g_head
            kcf_cell u_cell (
               .clock      (clock),
               .reset      (reset),
               .shift_en   (push),
               .prev_entry (new_entry),
               .prev_probe (inject),
               .entry      (entry_chain[gi]),
               .probe      (probe_chain[gi])
            );
         end else begin : g_body
            kcf_cell u_cell (
               .clock      (clock),
               .reset      (reset),
               .shift_en   (push),
               .prev_entry (entry_chain[gi-1]),
               .prev_probe (probe_chain[gi-1]),
               .entry      (entry_chain[gi]),
               .probe      (probe_chain[gi])
            );
         end
         assign probe_live[gi] = probe_chain[gi].valid;
      end
   endgenerate

   // latch the probe as it leaves the last cell
   always_comb begin
      walk_done_in = walk_done_ff;
      if (finish)                                 walk_done_in = 1'b0;
      else if (probe_chain[HISTORY_DEPTH-1].valid) walk_done_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) walk_done_ff <= 1'b0;
      else       walk_done_ff <= walk_done_in;
   end

   always_ff @(posedge clock) begin
      if (probe_chain[HISTORY_DEPTH-1].valid) begin
         walk_hit_ff  <= probe_chain[HISTORY_DEPTH-1].hit;
         walk_time_ff <= probe_chain[HISTORY_DEPTH-1].stamp;
      end
   end

   // verdict and state updates for the finished item
   assign pend_age = time_ff - pend_time_ff;
   assign delta    = time_ff - walk_time_ff;

   always_comb begin
      verdict       = kcf_pkg::VERDICT_PASS;
      rel_code      = '0;
      push          = 1'b0;
      pend_load     = 1'b0;
      pend_valid_in = pend_valid_ff;
      if (finish) begin
         priority if (func_ff == kcf_pkg::FUNC_TICK) begin
            verdict = kcf_pkg::VERDICT_IDLE;
            if (pend_valid_ff && (pend_age > repress_ff)) begin
               verdict       = kcf_pkg::VERDICT_ISSUED;
               rel_code      = pend_code_ff;
               pend_valid_in = 1'b0;
            end
         end else if (pend_valid_ff && (pend_key_ff == key_ff)) begin
            verdict       = kcf_pkg::VERDICT_ABSORBED;
            pend_valid_in = 1'b0;
            push          = 1'b1;
         end else begin
            if (walk_hit_ff) begin
               if (pressed_ff) begin
                  if ((delta < repress_ff) && !game_ff) verdict = kcf_pkg::VERDICT_BLOCKED;
               end else if (delta < short_ff) begin
                  verdict       = kcf_pkg::VERDICT_WITHHELD;
                  pend_load     = 1'b1;
                  pend_valid_in = 1'b1;
               end
            end
            push = (verdict == kcf_pkg::VERDICT_PASS);
         end
      end
   end

   // pending release
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         pend_key_ff   <= '0;
         pend_code_ff  <= '0;
         pend_time_ff  <= '0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         if (pend_load) begin
            pend_key_ff  <= key_ff;
            pend_code_ff <= code_ff;
            pend_time_ff <= time_ff;
         end
      end
   end

   // result register, freed by a transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish)          rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_verdict_ff <= verdict;
         rsp_code_ff    <= rel_code;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_verdict         = rsp_verdict_ff;
   assign rsp_release_keycode = rsp_code_ff;

`ifndef SYNTHESIS
   // at most one probe travels the row
   a_single_probe: assert property (@(posedge clock) disable iff (reset)
      $onehot0(probe_live))
      else $error("more than one probe in the cell row");

   // probes only move while an item is in work
   a_probe_busy: assert property (@(posedge clock) disable iff (reset)
      (probe_live != '0) |-> (state_ff == kcf_pkg::ST_BUSY))
      else $error("probe in the row while idle");

   // a withheld release leaves a pending release behind
   a_withheld_pends: assert property (@(posedge clock) disable iff (reset)
      (finish && (verdict == kcf_pkg::VERDICT_WITHHELD)) |=> pend_valid_ff)
      else $error("withheld release not pending");

   // an issued release clears the pending release
   a_issued_clears: assert property (@(posedge clock) disable iff (reset)
      (finish && (verdict == kcf_pkg::VERDICT_ISSUED)) |=> !pend_valid_ff)
      else $error("issued release still pending");

   // the history only shifts as an item finishes
   a_push_finish: assert property (@(posedge clock) disable iff (reset)
      push |-> (finish && (func_ff == kcf_pkg::FUNC_KEY)))
      else $error("history shift outside a key event finish");
`endif

endmodule
